FILE: rtl/dtfp_pkg.sv
// shared constants, status codes and the fraction term table for the decimal text converter
`default_nettype none

package dtfp_pkg;

  // number format
  localparam int WHOLE_BITS      = 32;
  localparam int FRAC_BITS       = 32;
  localparam int GUARD_BITS      = 8;
  localparam int MAX_FRAC_DIGITS = 12;

  // derived widths
  localparam int VALUE_W    = WHOLE_BITS + FRAC_BITS;
  localparam int ACC_W      = FRAC_BITS + GUARD_BITS;
  localparam int POS_W      = 5;
  localparam int TERM_IDX_W = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
  localparam int CHAR_W     = 8;
  localparam int STATUS_W   = 3;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_WHOLE = 3'd1,
    STAT_BAD_FRAC  = 3'd2,
    STAT_NO_WHOLE  = 3'd3,
    STAT_NO_FRAC   = 3'd4,
    STAT_OVERFLOW  = 3'd5
  } status_t;

  // term table: entry [k][d] is floor(d * 2^ACC_W / 10^(k+1))
  typedef logic [MAX_FRAC_DIGITS-1:0][9:0][ACC_W-1:0] term_tab_t;

  // built at elaboration by shift-subtract long division
  function automatic term_tab_t build_terms();
    term_tab_t         tab;
    longint unsigned   pw;
    longint unsigned   num;
    longint unsigned   rem;
    logic [ACC_W-1:0]  q;
    tab = '0;
    pw  = 1;
    for (int k = 0; k < MAX_FRAC_DIGITS; k++) begin
      pw = pw * 10;
      for (int d = 0; d < 10; d++) begin
        num = longint'(d) << ACC_W;
        rem = 0;
        q   = '0;
        for (int i = ACC_W + 3; i >= 0; i--) begin
          rem = (rem << 1) | ((num >> i) & 64'd1);
          if (rem >= pw) begin
            rem = rem - pw;
            if (i < ACC_W) begin
              q[i] = 1'b1;
            end
          end
        end
        tab[k][d] = q;
      end
    end
    return tab;
  endfunction

  localparam term_tab_t FRAC_TERM = build_terms();

endpackage

`default_nettype wire

FILE: rtl/decimal_text_to_fixed_point_core.sv
// decimal text to signed fixed-point converter, one character per request
//
// usage
//   in channel: one character per request. in_tdata carries the character,
//   in_tuser says whether the request holds a real character (0 = empty
//   request), in_tlast closes the string. only a request with in_tlast high
//   produces a result; all other requests only update the parse state.
//   out channel: one result per string, signed Q32.32 value on out_tdata and
//   a status code on out_tuser (0 ok, 1/2 bad character in whole/fraction,
//   3 no whole digit, 4 no nonzero fraction digit, 5 overflow, saturated).
// registers and throughput
//   a request is captured in an input register, then parsed, and a closing
//   request is finished into the result register. one request is taken
//   every cycle, except while a closing request waits in the input register
//   for the result register to be free.
// reset and stall
//   rst_n (synchronous, active low) empties both registers and returns the
//   parser to the start of a string. while a result waits on out_tready,
//   requests that do not close a string keep flowing; a closing request holds
//   in the input register until the result register is free.
`default_nettype none

module decimal_text_to_fixed_point_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [dtfp_pkg::CHAR_W-1:0]       in_tdata,   // [7:0] ch
  input  wire logic                              in_tuser,   // [0] has_char
  input  wire logic                              in_tlast,   // last character of the string
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic signed [dtfp_pkg::VALUE_W-1:0]    out_tdata,  // [63:0] value, signed Q32.32
  output logic [dtfp_pkg::STATUS_W-1:0]          out_tuser   // [2:0] status
);

  import dtfp_pkg::*;

  localparam int WP_W = WHOLE_BITS + 4;
  localparam logic [WP_W-1:0] WHOLE_LIM = WP_W'(1) << (WHOLE_BITS - 1);
  localparam logic [POS_W-1:0] POS_MAX  = '1;
  localparam logic [POS_W-1:0] POS_LIM  = POS_W'(MAX_FRAC_DIGITS);

  typedef enum logic [1:0] {
    PH_START,
    PH_WHOLE,
    PH_FRAC
  } phase_t;

  // input register
  logic              s1_v_r;
  logic [CHAR_W-1:0] s1_ch_r;
  logic              s1_has_r;
  logic              s1_last_r;

  // parse state
  phase_t                 phase_r, phase_nxt;
  status_t                err_r, err_nxt;
  logic                   neg_r, neg_nxt;
  logic [WHOLE_BITS-1:0]  whole_r, whole_nxt;
  logic [ACC_W-1:0]       frac_r, frac_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   seen_whole_r, seen_whole_nxt;
  logic                   seen_nz_r, seen_nz_nxt;

  // result register
  logic                   out_v_r;
  logic [VALUE_W-1:0]     out_value_r, out_value_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   adv;
  logic                   is_digit;
  logic [3:0]             dig;
  logic [WP_W-1:0]        whole_prod;
  logic [POS_W-1:0]       pos_m1;
  logic [TERM_IDX_W-1:0]  term_idx;
  logic [VALUE_W-1:0]     mag;

  // stage advance: only a closing request waits for the result register
  assign adv       = s1_v_r && (!s1_last_r || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;

  // character decode
  assign is_digit = (s1_ch_r >= "0") && (s1_ch_r <= "9");
  assign dig      = is_digit ? 4'(s1_ch_r - "0") : 4'd0;

  // whole part times ten plus digit
  assign whole_prod = (WP_W'(whole_r) << 3) + (WP_W'(whole_r) << 1) + WP_W'(dig);

  // parse step for one character
  always_comb begin
    phase_nxt      = phase_r;
    err_nxt        = err_r;
    neg_nxt        = neg_r;
    whole_nxt      = whole_r;
    frac_nxt       = frac_r;
    pos_nxt        = pos_r;
    seen_whole_nxt = seen_whole_r;
    seen_nz_nxt    = seen_nz_r;
    pos_m1         = '0;
    term_idx       = '0;
    if (s1_has_r && (err_r == STAT_OK)) begin
      if ((phase_r == PH_START) && (s1_ch_r == "+")) begin
        phase_nxt = PH_WHOLE;
      end else if ((phase_r == PH_START) && (s1_ch_r == "-")) begin
        phase_nxt = PH_WHOLE;
        neg_nxt   = 1'b1;
      end else if ((phase_r == PH_START) || (phase_r == PH_WHOLE)) begin
        phase_nxt = PH_WHOLE;
        if (s1_ch_r == ".") begin
          phase_nxt = PH_FRAC;
        end else if (!is_digit) begin
          err_nxt = STAT_BAD_WHOLE;
        end else begin
          whole_nxt      = (whole_prod > WHOLE_LIM) ? WHOLE_LIM[WHOLE_BITS-1:0]
                                                    : whole_prod[WHOLE_BITS-1:0];
          seen_whole_nxt = 1'b1;
        end
      end else begin
        if (!is_digit) begin
          err_nxt = STAT_BAD_FRAC;
        end else begin
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          if (dig != 4'd0) begin
            seen_nz_nxt = 1'b1;
          end
          pos_m1   = pos_nxt - POS_W'(1);
          term_idx = pos_m1[TERM_IDX_W-1:0];
          if (pos_nxt <= POS_LIM) begin
            frac_nxt = frac_r + FRAC_TERM[term_idx][dig];
          end
        end
      end
    end
  end

  // final value and status from the updated state
  assign mag = {whole_nxt, frac_nxt[ACC_W-1:GUARD_BITS]};

  always_comb begin
    out_value_nxt  = '0;
    out_status_nxt = STAT_OK;
    priority if (err_nxt != STAT_OK) begin
      out_status_nxt = err_nxt;
    end else if (!seen_whole_nxt) begin
      out_status_nxt = STAT_NO_WHOLE;
    end else if (!seen_nz_nxt) begin
      out_status_nxt = STAT_NO_FRAC;
    end else if (mag[VALUE_W-1] && (!neg_nxt || (mag[VALUE_W-2:0] != '0))) begin
      out_status_nxt = STAT_OVERFLOW;
      out_value_nxt  = neg_nxt ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      out_value_nxt  = neg_nxt ? (VALUE_W'(0) - mag) : mag;
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r   <= in_tdata;
      s1_has_r  <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  // parse state, back to start after each closing request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      err_r        <= STAT_OK;
      neg_r        <= 1'b0;
      whole_r      <= '0;
      frac_r       <= '0;
      pos_r        <= '0;
      seen_whole_r <= 1'b0;
      seen_nz_r    <= 1'b0;
    end else if (adv) begin
      if (s1_last_r) begin
        phase_r      <= PH_START;
        err_r        <= STAT_OK;
        neg_r        <= 1'b0;
        whole_r      <= '0;
        frac_r       <= '0;
        pos_r        <= '0;
        seen_whole_r <= 1'b0;
        seen_nz_r    <= 1'b0;
      end else begin
        phase_r      <= phase_nxt;
        err_r        <= err_nxt;
        neg_r        <= neg_nxt;
        whole_r      <= whole_nxt;
        frac_r       <= frac_nxt;
        pos_r        <= pos_nxt;
        seen_whole_r <= seen_whole_nxt;
        seen_nz_r    <= seen_nz_nxt;
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

FILE: rtl/dtfp_check.sv
// port-level checks for the decimal text converter, bound to the top level
`default_nettype none

module dtfp_check (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic signed [dtfp_pkg::VALUE_W-1:0] out_tdata,
  input wire logic [dtfp_pkg::STATUS_W-1:0]     out_tuser
);

  import dtfp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // rejected strings give a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_BAD_WHOLE || out_tuser == STAT_BAD_FRAC ||
                   out_tuser == STAT_NO_WHOLE || out_tuser == STAT_NO_FRAC)
    |-> out_tdata == '0)
    else $error("nonzero value on a rejected string");

  // only defined status codes appear on a result
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= STAT_OVERFLOW)
    else $error("undefined status code");

  // overflow gives one of the two saturation values
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_OVERFLOW)
    |-> (out_tdata == {1'b1, {(VALUE_W-1){1'b0}}}) || (out_tdata == {1'b0, {(VALUE_W-1){1'b1}}}))
    else $error("overflow value not saturated");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind decimal_text_to_fixed_point_core dtfp_check u_dtfp_check (.*);

`default_nettype wire
